// ===== hw/rtl/rcx_pkg.sv =====
// Shared item types and the elaboration-time linearization table builder.
package rcx_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LIN_MAX = 25;
    localparam int BIG_W = 400;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in;

    typedef struct packed {
        logic [15:0] chroma_x;
        logic [15:0] chroma_y;
        logic [16:0] luminance;
        logic        is_black;
    } t_out;

    function automatic logic [LIN_MAX-1:0] power_entry(input int unsigned v, input int frac);
        logic [BIG_W-1:0] den12;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] t;
        int unsigned num;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        num = 1000 * v + 14025;
        den12 = BIG_W'(1);
        rhs = BIG_W'(1);
        for (int i = 0; i < 12; i++) begin
            den12 = den12 * BIG_W'(269025);
            rhs = rhs * BIG_W'(num);
        end
        rhs = rhs << (5 * (frac + 1));
        lo = 0;
        hi = (32'd1 << (frac + 1)) + 1;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            t = den12;
            for (int i = 0; i < 5; i++) begin
                t = t * BIG_W'(mid);
            end
            if (t <= rhs) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return LIN_MAX'((lo + 1) >> 1);
    endfunction

    function automatic logic [256*LIN_MAX-1:0] build_lin(input int frac);
        logic [256*LIN_MAX-1:0] tab;
        longint unsigned lin;
        tab = '0;
        for (int v = 0; v < 256; v++) begin
            if (v <= 10) begin
                lin = (((longint'(v) * 10) << frac) + 16473) / 32946;
                tab[v*LIN_MAX +: LIN_MAX] = LIN_MAX'(lin);
            end else begin
                tab[v*LIN_MAX +: LIN_MAX] = power_entry(v, frac);
            end
        end
        return tab;
    endfunction

endpackage

// ===== hw/rtl/rgb8_to_cie_xyy_top.sv =====
// Top level: sRGB pixel to CIE xyY, front stages followed by a chain of divider cells.
//  port       dir  role
//  i_start    in   item offered, with i_in
//  o_busy     out  always low, an item is taken every cycle
//  o_valid    out  result strobe, with o_result
// One item may be accepted in every cycle.
// Each item passes through three front stages, one divider cell per quotient bit,
// and the output register.
// Reset clears all valid flags; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module rgb8_to_cie_xyy_top #(
    parameter int FRAC_BITS = rcx_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  rcx_pkg::t_in  i_in,
    output logic          o_valid,
    output rcx_pkg::t_out o_result
);
    import rcx_pkg::*;

    localparam int SW = FRAC_BITS + 15;
    localparam int QW = FRAC_BITS + 1;
    localparam int LAT = FRAC_BITS + 5;

    logic               c_valid [QW+1];
    logic [2:0][SW-1:0] c_div [QW+1];
    logic [2:0][SW-1:0] c_rem [QW+1];
    logic [2:0][QW-1:0] c_num [QW+1];
    logic [2:0][QW-1:0] c_q [QW+1];
    logic               c_black [QW+1];
    logic [31:0]        qx, qy, ql;
    logic               r_valid;

    assign o_busy = 1'b0;
    assign c_q[0] = '0;

    rcx_front #(.FRAC_BITS(FRAC_BITS), .SW(SW), .QW(QW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_start), .i_in(i_in),
        .o_valid(c_valid[0]), .o_div(c_div[0]), .o_rem(c_rem[0]),
        .o_num(c_num[0]), .o_black(c_black[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_cell
        rcx_div_cell #(.SW(SW), .QW(QW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(c_valid[g]), .i_div(c_div[g]), .i_rem(c_rem[g]),
            .i_num(c_num[g]), .i_q(c_q[g]), .i_black(c_black[g]),
            .o_valid(c_valid[g+1]), .o_div(c_div[g+1]), .o_rem(c_rem[g+1]),
            .o_num(c_num[g+1]), .o_q(c_q[g+1]), .o_black(c_black[g+1])
        );
    end

    assign qx = 32'(c_q[QW][0]);
    assign qy = 32'(c_q[QW][1]);
    assign ql = 32'(c_q[QW][2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= c_valid[QW];
        end
        o_result.chroma_x <= c_black[QW] ? '0 : qx[15:0];
        o_result.chroma_y <= c_black[QW] ? '0 : qy[15:0];
        o_result.luminance <= c_black[QW] ? '0 : ql[16:0];
        o_result.is_black <= c_black[QW];
    end

    assign o_valid = r_valid;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without a matching item");
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.is_black |->
            o_result.chroma_x == '0 && o_result.chroma_y == '0 && o_result.luminance == '0)
        else $error("black item with nonzero fields");
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> ##(LAT-1) o_valid)
        else $error("accepted item lost");
`endif

endmodule

// ===== hw/rtl/rcx_front.sv =====
// Linearization lookup, color matrix and divider setup, three pipeline stages.
module rcx_front #(
    parameter int FRAC_BITS = rcx_pkg::FRAC_BITS_DEF,
    parameter int SW = FRAC_BITS + 15,
    parameter int QW = FRAC_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rcx_pkg::t_in          i_in,
    output logic                  o_valid,
    output logic [2:0][SW-1:0]    o_div,
    output logic [2:0][SW-1:0]    o_rem,
    output logic [2:0][QW-1:0]    o_num,
    output logic                  o_black
);
    import rcx_pkg::*;

    localparam int LW = FRAC_BITS + 1;
    localparam int NW = SW + QW;
    localparam logic [256*LIN_MAX-1:0] TAB = build_lin(FRAC_BITS);

    logic [2:0]    r_valid;
    logic [LW-1:0] r_lr, r_lg, r_lb;
    logic [SW-1:0] r_xn, r_yn, r_zn;
    logic [SW-1:0] n_xn, n_yn, n_zn;
    logic [SW-1:0] sum;
    logic [NW-1:0] num_x, num_y, num_l;

    always_comb begin
        n_xn = SW'(4124) * SW'(r_lr) + SW'(3576) * SW'(r_lg) + SW'(1805) * SW'(r_lb);
        n_yn = SW'(2126) * SW'(r_lr) + SW'(7152) * SW'(r_lg) + SW'(722) * SW'(r_lb);
        n_zn = SW'(193) * SW'(r_lr) + SW'(1192) * SW'(r_lg) + SW'(9505) * SW'(r_lb);
        sum = r_xn + r_yn + r_zn;
        num_x = (NW'(r_xn) << FRAC_BITS) + NW'(sum >> 1);
        num_y = (NW'(r_yn) << FRAC_BITS) + NW'(sum >> 1);
        num_l = NW'(r_yn) + NW'(5000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        r_lr <= TAB[i_in.red * LIN_MAX +: LW];
        r_lg <= TAB[i_in.green * LIN_MAX +: LW];
        r_lb <= TAB[i_in.blue * LIN_MAX +: LW];
        r_xn <= n_xn;
        r_yn <= n_yn;
        r_zn <= n_zn;
        o_div[0] <= sum;
        o_div[1] <= sum;
        o_div[2] <= SW'(10000);
        o_rem[0] <= num_x[NW-1:QW];
        o_rem[1] <= num_y[NW-1:QW];
        o_rem[2] <= num_l[NW-1:QW];
        o_num[0] <= num_x[QW-1:0];
        o_num[1] <= num_y[QW-1:0];
        o_num[2] <= num_l[QW-1:0];
        o_black <= (sum == '0);
    end

    assign o_valid = r_valid[2];

endmodule

// ===== hw/rtl/rcx_div_cell.sv =====
// One restoring division step for three lanes, registered.
module rcx_div_cell #(
    parameter int SW = 31,
    parameter int QW = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [2:0][SW-1:0] i_div,
    input  logic [2:0][SW-1:0] i_rem,
    input  logic [2:0][QW-1:0] i_num,
    input  logic [2:0][QW-1:0] i_q,
    input  logic               i_black,
    output logic               o_valid,
    output logic [2:0][SW-1:0] o_div,
    output logic [2:0][SW-1:0] o_rem,
    output logic [2:0][QW-1:0] o_num,
    output logic [2:0][QW-1:0] o_q,
    output logic               o_black
);
    logic [2:0][SW:0]   t;
    logic [2:0][SW:0]   d;
    logic [2:0]         ge;
    logic [2:0][SW-1:0] n_rem;
    logic [2:0][QW-1:0] n_q;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t[k] = {i_rem[k], i_num[k][QW-1]};
            ge[k] = t[k] >= {1'b0, i_div[k]};
            d[k] = t[k] - {1'b0, i_div[k]};
            n_rem[k] = ge[k] ? d[k][SW-1:0] : t[k][SW-1:0];
            n_q[k] = {i_q[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_div <= i_div;
        o_rem <= n_rem;
        for (int k = 0; k < 3; k++) begin
            o_num[k] <= i_num[k] << 1;
        end
        o_q <= n_q;
        o_black <= i_black;
    end

endmodule

// ===== test/rgb8_to_cie_xyy_top_tb.sv =====
// Self-checking testbench for the sRGB to CIE xyY converter with a scoreboard class.
`timescale 1ns / 1ps

module rgb8_to_cie_xyy_top_tb;

    import rcx_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = FB + 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1500;

    class xyy_scoreboard;
        logic [24:0] lin_lut [256];
        t_out pending_xyy [$];
        int fail_count;

        function new();
            fail_count = 0;
            for (int v = 0; v < 256; v++) begin
                lin_lut[v] = linearize(v);
            end
        endfunction

        function logic [24:0] linearize(int v);
            logic [399:0] den;
            logic [399:0] rhs;
            logic [399:0] t;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            longint unsigned num;
            if (v <= 10) begin
                return 25'((((longint'(v) * 10) << FB) + 16473) / 32946);
            end
            num = 1000 * v + 14025;
            den = 1;
            rhs = 1;
            for (int i = 0; i < 12; i++) begin
                den = den * 400'(269025);
                rhs = rhs * 400'(num);
            end
            rhs = rhs << (5 * (FB + 1));
            lo = 0;
            hi = (64'd1 << (FB + 1)) + 1;
            while (hi - lo > 1) begin
                mid = lo + (hi - lo) / 2;
                t = den;
                for (int i = 0; i < 5; i++) begin
                    t = t * 400'(mid);
                end
                if (t <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            return 25'((lo + 1) >> 1);
        endfunction

        function void note_pixel(t_in px);
            longint unsigned r, g, b, xn, yn, zn, sum;
            t_out e;
            r = lin_lut[px.red];
            g = lin_lut[px.green];
            b = lin_lut[px.blue];
            xn = 4124 * r + 3576 * g + 1805 * b;
            yn = 2126 * r + 7152 * g + 722 * b;
            zn = 193 * r + 1192 * g + 9505 * b;
            sum = xn + yn + zn;
            e = '0;
            if (sum == 0) begin
                e.is_black = 1'b1;
            end else begin
                e.chroma_x = 16'(((xn << FB) + sum / 2) / sum);
                e.chroma_y = 16'(((yn << FB) + sum / 2) / sum);
                e.luminance = 17'((yn + 5000) / 10000);
            end
            pending_xyy.push_back(e);
        endfunction

        function void check_xyy(t_out got);
            t_out e;
            if (pending_xyy.size() == 0) begin
                $error("unexpected result %h", got);
                fail_count++;
                return;
            end
            e = pending_xyy.pop_front();
            if (got.chroma_x !== e.chroma_x) begin
                $error("chroma_x expected %0d actual %0d", e.chroma_x, got.chroma_x);
                fail_count++;
            end
            if (got.chroma_y !== e.chroma_y) begin
                $error("chroma_y expected %0d actual %0d", e.chroma_y, got.chroma_y);
                fail_count++;
            end
            if (got.luminance !== e.luminance) begin
                $error("luminance expected %0d actual %0d", e.luminance, got.luminance);
                fail_count++;
            end
            if (got.is_black !== e.is_black) begin
                $error("is_black expected %0d actual %0d", e.is_black, got.is_black);
                fail_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    t_in i_in;
    logic o_valid;
    t_out o_result;

    xyy_scoreboard sb;
    int idle_cycles;
    bit calm_stretch;

    rgb8_to_cie_xyy_top #(.FRAC_BITS(FB)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_in(i_in),
        .o_valid(o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                sb.note_pixel(i_in);
            end
            if (o_valid) begin
                sb.check_xyy(o_result);
            end
            if ((i_start && !o_busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (!calm_stretch && $urandom_range(99) < 32) begin
            i_start <= 1'b0;
            i_in <= t_in'(24'($urandom));
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_in <= '{red: r, green: g, blue: b};
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        calm_stretch = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd10, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd11, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd1);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_stretch = (n >= 600 && n < 900);
            if ($urandom_range(9) == 0) begin
                send_pixel(8'($urandom_range(12)), 8'($urandom_range(12)),
                           8'($urandom_range(12)));
            end else begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        i_start <= 1'b0;
        while (sb.pending_xyy.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 5) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
